[design/c2db_pkg.sv]
// Shared types, codes and constants of the 2D convolution core.
// No dependencies; the core takes everything by scoped names.
package c2db_pkg;

   // default sizing of the on-chip stores
   localparam int MAX_CHANNELS_DEF = 16;
   localparam int MAX_DIM_DEF      = 32;
   localparam int MAX_KERNEL_DEF   = 5;
   localparam int MAX_FILTERS_DEF  = 32;

   // fixed field widths
   localparam int DATA_W  = 16;
   localparam int VALUE_W = 32;
   localparam int CSR_W   = 32;
   localparam int CSR_AW  = 5;
   // signed patch coordinate: covers -pad .. 31*4 + kernel
   localparam int POS_W   = 10;

   // bias is Q8.8, the sum is Q16.16
   localparam logic signed [DATA_W-1:0] BIAS_SCALE = 16'sd256;

   // register reset values
   localparam logic [4:0] RST_IN_CHANNELS   = 5'd3;
   localparam logic [5:0] RST_IN_HEIGHT     = 6'd32;
   localparam logic [5:0] RST_IN_WIDTH      = 6'd32;
   localparam logic [2:0] RST_KERNEL_HEIGHT = 3'd3;
   localparam logic [2:0] RST_KERNEL_WIDTH  = 3'd3;
   localparam logic [2:0] RST_STEP_SIZE     = 3'd1;
   localparam logic [1:0] RST_PAD_AMOUNT    = 2'd1;
   localparam logic [5:0] RST_NUM_FILTERS   = 6'd16;

   typedef enum logic [2:0] {
      REG_IN_CHANNELS   = 3'd0,
      REG_IN_HEIGHT     = 3'd1,
      REG_IN_WIDTH      = 3'd2,
      REG_KERNEL_HEIGHT = 3'd3,
      REG_KERNEL_WIDTH  = 3'd4,
      REG_STEP_SIZE     = 3'd5,
      REG_PAD_AMOUNT    = 3'd6,
      REG_NUM_FILTERS   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_PIXEL   = 2'd0,
      CMD_WEIGHT  = 2'd1,
      CMD_BIAS    = 2'd2,
      CMD_COMPUTE = 2'd3
   } command_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // register value forced into [lo, hi]
   function automatic logic [7:0] clamp_cfg(input logic [7:0] value, input int lo,
                                            input int hi);
      logic [7:0] res;
      res = value;
      if (int'(value) < lo) res = 8'(lo);
      else if (int'(value) > hi) res = 8'(hi);
      return res;
   endfunction

endpackage

[design/conv2d_forward_with_bias_core.sv]
// 2D convolution core with per-filter bias, zero padding and stride.
// Depends on c2db_pkg for codes, reset values and the register clamp.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+------------------------------
//  request  | req_* fields                       | word taken when start & !busy
//  result   | rsp_* fields                       | rsp_strobe, one cycle, no stall
//  config   | psel penable pwrite paddr pwdata   | write on psel&penable&pwrite,
//           | prdata pready                      | pready tied high
//
// A pixel, weight or bias write returns no word and does not raise busy.
// A compute word keeps busy high through the check state, one multiply-accumulate
// per cycle over nc*kh*kw taps (nc channels, kh by kw kernel, after clamping),
// set by the single read port of each store, the drain state and the result
// state. An out-of-range query goes from the check state straight to the result.
// Reset loads the register reset values; the stores hold garbage until written.
// The result receiver cannot stall, so the result shows exactly once.
module conv2d_forward_with_bias_core #(
   parameter int MAX_CHANNELS = c2db_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_DIM      = c2db_pkg::MAX_DIM_DEF,
   parameter int MAX_KERNEL   = c2db_pkg::MAX_KERNEL_DEF,
   parameter int MAX_FILTERS  = c2db_pkg::MAX_FILTERS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [4:0]                   req_filter_index,
   input  logic [3:0]                   req_channel_index,
   input  logic [4:0]                   req_row_index,
   input  logic [4:0]                   req_col_index,
   input  logic signed [15:0]           req_data_value,
   // result channel
   output logic                         rsp_strobe,
   output logic signed [31:0]           rsp_out_value,
   output logic [4:0]                   rsp_out_filter,
   output logic [4:0]                   rsp_out_row,
   output logic [4:0]                   rsp_out_col,
   output logic                         rsp_in_range,
   // configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [c2db_pkg::CSR_AW-1:0]  paddr,
   input  logic [c2db_pkg::CSR_W-1:0]   pwdata,
   output logic [c2db_pkg::CSR_W-1:0]   prdata,
   output logic                         pready
);

   localparam int POS_W     = c2db_pkg::POS_W;
   localparam int IMG_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
   localparam int WGT_AREA  = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   // biases sit right after the weights in the same store
   localparam int WGT_DEPTH = WGT_AREA + MAX_FILTERS;
   localparam int IMG_AW    = $clog2(IMG_DEPTH);
   localparam int WGT_AW    = $clog2(WGT_DEPTH);
   localparam int CH_W      = $clog2(MAX_CHANNELS + 1);
   localparam int KC_W      = $clog2(MAX_KERNEL + 1);
   localparam int ACC_W     = 34 + $clog2(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1);

   localparam int NC_TOP = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
   localparam int DIM_TOP = (MAX_DIM < 32) ? MAX_DIM : 32;
   localparam int K_TOP  = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;
   localparam int NF_TOP = (MAX_FILTERS < 32) ? MAX_FILTERS : 32;

   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W)'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = (ACC_W)'(-64'sd2147483648);

   // ---------------------------------------------------------------- config
   logic [4:0] cfg_in_channels_ff, cfg_in_channels_in;
   logic [5:0] cfg_in_height_ff, cfg_in_height_in;
   logic [5:0] cfg_in_width_ff, cfg_in_width_in;
   logic [2:0] cfg_kernel_height_ff, cfg_kernel_height_in;
   logic [2:0] cfg_kernel_width_ff, cfg_kernel_width_in;
   logic [2:0] cfg_step_size_ff, cfg_step_size_in;
   logic [1:0] cfg_pad_amount_ff, cfg_pad_amount_in;
   logic [5:0] cfg_num_filters_ff, cfg_num_filters_in;

   logic                    csr_we;
   c2db_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_we    = psel & penable & pwrite & pready;
   assign csr_index = c2db_pkg::reg_index_type'(paddr[4:2]);

   always_comb begin
      cfg_in_channels_in   = cfg_in_channels_ff;
      cfg_in_height_in     = cfg_in_height_ff;
      cfg_in_width_in      = cfg_in_width_ff;
      cfg_kernel_height_in = cfg_kernel_height_ff;
      cfg_kernel_width_in  = cfg_kernel_width_ff;
      cfg_step_size_in     = cfg_step_size_ff;
      cfg_pad_amount_in    = cfg_pad_amount_ff;
      cfg_num_filters_in   = cfg_num_filters_ff;
      prdata               = '0;
      unique case (csr_index)
         c2db_pkg::REG_IN_CHANNELS: begin
            if (csr_we) cfg_in_channels_in = pwdata[4:0];
            prdata = 32'(cfg_in_channels_ff);
         end
         c2db_pkg::REG_IN_HEIGHT: begin
            if (csr_we) cfg_in_height_in = pwdata[5:0];
            prdata = 32'(cfg_in_height_ff);
         end
         c2db_pkg::REG_IN_WIDTH: begin
            if (csr_we) cfg_in_width_in = pwdata[5:0];
            prdata = 32'(cfg_in_width_ff);
         end
         c2db_pkg::REG_KERNEL_HEIGHT: begin
            if (csr_we) cfg_kernel_height_in = pwdata[2:0];
            prdata = 32'(cfg_kernel_height_ff);
         end
         c2db_pkg::REG_KERNEL_WIDTH: begin
            if (csr_we) cfg_kernel_width_in = pwdata[2:0];
            prdata = 32'(cfg_kernel_width_ff);
         end
         c2db_pkg::REG_STEP_SIZE: begin
            if (csr_we) cfg_step_size_in = pwdata[2:0];
            prdata = 32'(cfg_step_size_ff);
         end
         c2db_pkg::REG_PAD_AMOUNT: begin
            if (csr_we) cfg_pad_amount_in = pwdata[1:0];
            prdata = 32'(cfg_pad_amount_ff);
         end
         c2db_pkg::REG_NUM_FILTERS: begin
            if (csr_we) cfg_num_filters_in = pwdata[5:0];
            prdata = 32'(cfg_num_filters_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_in_channels_ff   <= c2db_pkg::RST_IN_CHANNELS;
         cfg_in_height_ff     <= c2db_pkg::RST_IN_HEIGHT;
         cfg_in_width_ff      <= c2db_pkg::RST_IN_WIDTH;
         cfg_kernel_height_ff <= c2db_pkg::RST_KERNEL_HEIGHT;
         cfg_kernel_width_ff  <= c2db_pkg::RST_KERNEL_WIDTH;
         cfg_step_size_ff     <= c2db_pkg::RST_STEP_SIZE;
         cfg_pad_amount_ff    <= c2db_pkg::RST_PAD_AMOUNT;
         cfg_num_filters_ff   <= c2db_pkg::RST_NUM_FILTERS;
      end else begin
         cfg_in_channels_ff   <= cfg_in_channels_in;
         cfg_in_height_ff     <= cfg_in_height_in;
         cfg_in_width_ff      <= cfg_in_width_in;
         cfg_kernel_height_ff <= cfg_kernel_height_in;
         cfg_kernel_width_ff  <= cfg_kernel_width_in;
         cfg_step_size_ff     <= cfg_step_size_in;
         cfg_pad_amount_ff    <= cfg_pad_amount_in;
         cfg_num_filters_ff   <= cfg_num_filters_in;
      end
   end

   // clamped working values
   logic [7:0]      nc_w, ih_w, iw_w, kh_w, kw_w, st_w, pd_w, nf_w;
   logic [CH_W-1:0] nc;
   logic [5:0]      ih, iw, nf;
   logic [KC_W-1:0] kh, kw;
   logic [2:0]      st;
   logic [1:0]      pd;

   assign nc_w = c2db_pkg::clamp_cfg(8'(cfg_in_channels_ff), 1, NC_TOP);
   assign ih_w = c2db_pkg::clamp_cfg(8'(cfg_in_height_ff), 1, DIM_TOP);
   assign iw_w = c2db_pkg::clamp_cfg(8'(cfg_in_width_ff), 1, DIM_TOP);
   assign kh_w = c2db_pkg::clamp_cfg(8'(cfg_kernel_height_ff), 1, K_TOP);
   assign kw_w = c2db_pkg::clamp_cfg(8'(cfg_kernel_width_ff), 1, K_TOP);
   assign st_w = c2db_pkg::clamp_cfg(8'(cfg_step_size_ff), 1, 4);
   assign pd_w = c2db_pkg::clamp_cfg(8'(cfg_pad_amount_ff), 0, 2);
   assign nf_w = c2db_pkg::clamp_cfg(8'(cfg_num_filters_ff), 1, NF_TOP);
   assign nc   = nc_w[CH_W-1:0];
   assign ih   = ih_w[5:0];
   assign iw   = iw_w[5:0];
   assign kh   = kh_w[KC_W-1:0];
   assign kw   = kw_w[KC_W-1:0];
   assign st   = st_w[2:0];
   assign pd   = pd_w[1:0];
   assign nf   = nf_w[5:0];

   // ---------------------------------------------------------------- writes
   logic accept;
   logic img_we, wgt_we;
   logic [IMG_AW-1:0] img_wr_addr;
   logic [WGT_AW-1:0] wgt_wr_addr;
   logic [31:0] img_wr_full, wgt_wr_full;
   logic [15:0] wgt_wr_data;

   assign accept = start & ~busy;

   always_comb begin
      img_wr_full = (32'(req_channel_index) * MAX_DIM + 32'(req_row_index)) * MAX_DIM
                    + 32'(req_col_index);
      wgt_wr_full = ((32'(req_filter_index) * MAX_CHANNELS + 32'(req_channel_index))
                     * MAX_KERNEL + 32'(req_row_index)) * MAX_KERNEL + 32'(req_col_index);
      img_we      = 1'b0;
      wgt_we      = 1'b0;
      img_wr_addr = img_wr_full[IMG_AW-1:0];
      wgt_wr_addr = wgt_wr_full[WGT_AW-1:0];
      wgt_wr_data = req_data_value;
      if (accept) begin
         unique case (c2db_pkg::command_type'(req_command))
            c2db_pkg::CMD_PIXEL: begin
               img_we = (32'(req_channel_index) < MAX_CHANNELS)
                        && (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
            end
            c2db_pkg::CMD_WEIGHT: begin
               wgt_we = (32'(req_filter_index) < MAX_FILTERS)
                        && (32'(req_channel_index) < MAX_CHANNELS)
                        && (32'(req_row_index) < MAX_KERNEL)
                        && (32'(req_col_index) < MAX_KERNEL);
            end
            c2db_pkg::CMD_BIAS: begin
               wgt_we      = 32'(req_filter_index) < MAX_FILTERS;
               wgt_wr_addr = WGT_AW'(32'(WGT_AREA) + 32'(req_filter_index));
            end
            c2db_pkg::CMD_COMPUTE: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   c2db_pkg::state_type state_ff, state_in;
   logic [4:0]            f_ff, f_in, r_ff, r_in, c_ff, c_in;
   logic                  ok_ff, ok_in;
   logic signed [POS_W-1:0] rb_ff, rb_in, cb_ff, cb_in;
   logic [CH_W-1:0]       k_ff, k_in;
   logic [KC_W-1:0]       i_ff, i_in, j_ff, j_in;
   logic                  drain_ff, drain_in;

   // range test without a divide: r < oh  <=>  r*st + kh <= ih + 2*pd
   logic [8:0] rs, cs;
   logic       check_ok;
   assign rs = 9'(r_ff) * 9'(st);
   assign cs = 9'(c_ff) * 9'(st);
   assign check_ok = (6'(f_ff) < nf)
                     && (rs + 9'(kh) <= 9'(ih) + 9'({pd, 1'b0}))
                     && (cs + 9'(kw) <= 9'(iw) + 9'({pd, 1'b0}));

   // current patch tap
   logic signed [POS_W-1:0] pr, pc;
   logic                    tap_in;
   logic                    last_j, last_i, last_k;
   logic [31:0]             img_rd_full, wgt_rd_full;
   logic [IMG_AW-1:0]       img_rd_addr;
   logic [WGT_AW-1:0]       wgt_rd_addr;

   assign pr = rb_ff + $signed(POS_W'(i_ff));
   assign pc = cb_ff + $signed(POS_W'(j_ff));
   assign tap_in = !pr[POS_W-1] && (pr < $signed(POS_W'(ih)))
                   && !pc[POS_W-1] && (pc < $signed(POS_W'(iw)));
   assign last_j = (j_ff == kw - KC_W'(1));
   assign last_i = (i_ff == kh - KC_W'(1));
   assign last_k = (k_ff == nc - CH_W'(1));

   always_comb begin
      img_rd_full = (32'(k_ff) * MAX_DIM + 32'(unsigned'(pr))) * MAX_DIM
                    + 32'(unsigned'(pc));
      wgt_rd_full = ((32'(f_ff) * MAX_CHANNELS + 32'(k_ff)) * MAX_KERNEL + 32'(i_ff))
                    * MAX_KERNEL + 32'(j_ff);
      img_rd_addr = tap_in ? img_rd_full[IMG_AW-1:0] : '0;
      if (state_ff == c2db_pkg::ST_CHECK) wgt_rd_addr = WGT_AW'(32'(WGT_AREA) + 32'(f_ff));
      else wgt_rd_addr = wgt_rd_full[WGT_AW-1:0];
   end

   // pipeline flags: s1 = read data, s2 = product
   logic s1_valid_ff, s1_valid_in, s1_bias_ff, s1_bias_in;
   logic s2_valid_ff;

   always_comb begin
      state_in    = state_ff;
      f_in        = f_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      ok_in       = ok_ff;
      rb_in       = rb_ff;
      cb_in       = cb_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      drain_in    = drain_ff;
      s1_valid_in = 1'b0;
      s1_bias_in  = 1'b0;
      unique case (state_ff)
         c2db_pkg::ST_IDLE: begin
            if (accept && (c2db_pkg::command_type'(req_command) == c2db_pkg::CMD_COMPUTE)) begin
               f_in     = req_filter_index;
               r_in     = req_row_index;
               c_in     = req_col_index;
               state_in = c2db_pkg::ST_CHECK;
            end
         end
         c2db_pkg::ST_CHECK: begin
            // bias read goes out in this cycle; it counts only when the query is in range
            ok_in       = check_ok;
            rb_in       = $signed(POS_W'(rs)) - $signed(POS_W'(pd));
            cb_in       = $signed(POS_W'(cs)) - $signed(POS_W'(pd));
            k_in        = '0;
            i_in        = '0;
            j_in        = '0;
            drain_in    = 1'b0;
            s1_valid_in = check_ok;
            s1_bias_in  = 1'b1;
            state_in    = check_ok ? c2db_pkg::ST_RUN : c2db_pkg::ST_DONE;
         end
         c2db_pkg::ST_RUN: begin
            s1_valid_in = tap_in;
            if (!last_j) begin
               j_in = j_ff + KC_W'(1);
            end else begin
               j_in = '0;
               if (!last_i) begin
                  i_in = i_ff + KC_W'(1);
               end else begin
                  i_in = '0;
                  if (!last_k) k_in = k_ff + CH_W'(1);
                  else state_in = c2db_pkg::ST_DRAIN;
               end
            end
         end
         c2db_pkg::ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) state_in = c2db_pkg::ST_DONE;
         end
         c2db_pkg::ST_DONE: begin
            state_in = c2db_pkg::ST_IDLE;
         end
         default: begin
            state_in = c2db_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= c2db_pkg::ST_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         drain_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         drain_ff    <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff       <= f_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      ok_ff      <= ok_in;
      rb_ff      <= rb_in;
      cb_ff      <= cb_in;
      k_ff       <= k_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      s1_bias_ff <= s1_bias_in;
   end

   // ---------------------------------------------------------------- stores
   logic [15:0] img_mem [IMG_DEPTH];
   logic [15:0] wgt_mem [WGT_DEPTH];
   logic [15:0] img_q_ff, wgt_q_ff;

   always_ff @(posedge clock) begin
      if (img_we) img_mem[img_wr_addr] <= req_data_value;
      img_q_ff <= img_mem[img_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wgt_we) wgt_mem[wgt_wr_addr] <= wgt_wr_data;
      wgt_q_ff <= wgt_mem[wgt_rd_addr];
   end

   // ---------------------------------------------------------------- MAC
   logic signed [15:0]      op_a;
   logic signed [31:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // bias slot rides the multiplier as bias * 256
   assign op_a    = s1_bias_ff ? c2db_pkg::BIAS_SCALE : $signed(img_q_ff);
   assign prod_in = op_a * $signed(wgt_q_ff);

   always_comb begin
      if (state_ff == c2db_pkg::ST_CHECK) acc_in = '0;
      else if (s2_valid_ff) acc_in = acc_ff + (ACC_W)'(prod_ff);
      else acc_in = acc_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // ---------------------------------------------------------------- result
   logic signed [31:0] sat_value;

   always_comb begin
      priority if (acc_ff > SAT_HI) sat_value = 32'sh7FFFFFFF;
      else if (acc_ff < SAT_LO) sat_value = 32'sh80000000;
      else sat_value = acc_ff[31:0];
   end

   assign busy           = (state_ff != c2db_pkg::ST_IDLE);
   assign rsp_strobe     = (state_ff == c2db_pkg::ST_DONE);
   assign rsp_out_value  = ok_ff ? sat_value : 32'sd0;
   assign rsp_out_filter = f_ff;
   assign rsp_out_row    = r_ff;
   assign rsp_out_col    = c_ff;
   assign rsp_in_range   = ok_ff;

endmodule
